// ===== design/lcbd_pkg.sv =====
`default_nettype none
package lcbd_pkg;

    localparam int LCBD_MAX_BITS = 32;
    localparam logic [5:0] WORD_LENGTH_RESET = 6'd32;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DECODE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_PA,
        S_PB,
        S_PC,
        S_STR,
        S_DRN,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        JOB_INSERT,
        JOB_SYND,
        JOB_TABLE
    } t_job;

    // Request from the sequencer to the basis unit.
    typedef struct packed {
        logic start;
        logic insert;
        logic clear;
    } t_red_req;

    typedef struct packed {
        logic done;
    } t_red_rsp;

endpackage
`default_nettype wire

// ===== design/lcbd_basis.sv =====
`default_nettype none
module lcbd_basis
    import lcbd_pkg::*;
#(
    parameter int MAX_BITS = LCBD_MAX_BITS,
    localparam int IW = $clog2(MAX_BITS),
    localparam int CW = $clog2(MAX_BITS + 1)
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  t_red_req      i_req,
    input  wire  [MAX_BITS-1:0] i_word,
    input  wire  [CW-1:0]       i_len,
    input  wire  [MAX_BITS-1:0] i_mask,
    output t_red_rsp            o_rsp,
    output logic [MAX_BITS-1:0] o_rem
);

    logic [MAX_BITS-1:0] basis_mem [MAX_BITS];
    logic [MAX_BITS-1:0] r_rdata;
    logic [MAX_BITS-1:0] r_pv;
    logic [MAX_BITS-1:0] r_w;
    logic [CW-1:0]       r_i;
    logic                r_busy;
    logic                r_ins;

    logic [CW:0]         i_plus;
    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       bit_idx;
    logic                apply;
    logic                last;
    logic [MAX_BITS-1:0] n_w;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;

    function automatic logic [IW-1:0] low_bit(input logic [MAX_BITS-1:0] v);
        logic [IW-1:0] r;
        r = '0;
        for (int k = MAX_BITS - 1; k >= 0; k--) begin
            if (v[k]) begin
                r = IW'(k);
            end
        end
        return r;
    endfunction

    assign i_plus  = (CW + 1)'(r_i) + (CW + 1)'(1);
    assign rd_addr = i_req.start ? '0 : i_plus[IW-1:0];
    assign bit_idx = r_i[IW-1:0];
    assign apply   = (r_i < i_len) && r_w[bit_idx] && r_pv[bit_idx];
    assign n_w     = apply ? (r_w ^ (r_rdata & i_mask)) : r_w;
    assign last    = i_plus >= (CW + 1)'(i_len);

    assign o_rsp.done = r_busy && last;
    assign o_rem      = n_w;
    assign wr_en      = r_busy && last && r_ins && (n_w != '0);
    assign wr_addr    = low_bit(n_w);

    always_ff @(posedge i_clk) begin
        r_rdata <= basis_mem[rd_addr];
        if (wr_en) begin
            basis_mem[wr_addr] <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= '0;
        end else begin
            if (i_req.clear) begin
                r_pv <= '0;
            end else if (wr_en) begin
                r_pv[wr_addr] <= 1'b1;
            end
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_w   <= i_word;
            r_i   <= '0;
            r_ins <= i_req.insert;
        end else if (r_busy) begin
            r_w <= n_w;
            r_i <= i_plus[CW-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== design/linear_code_bounded_distance_decoder.sv =====
`default_nettype none
// A clear empties the basis without leaving idle; an insert reduces the word by the basis
// and stores a nonzero remainder as a new row. Decode reduces the word to its syndrome,
// builds the syndrome table one bit at a time, then streams flip patterns of weight 1..3,
// loading each pair or triple prefix before streaming the remaining bit.
// Throughput is one item at a time: the input stalls until the current command ends.
// Reset (synchronous, active low) empties the basis and sets word length to 32.
module linear_code_bounded_distance_decoder
    import lcbd_pkg::*;
#(
    parameter int MAX_BITS = LCBD_MAX_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [5:0]  i_cfg_data,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_command,
    input  wire  [31:0] i_data_word,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_found,
    output logic [31:0] o_codeword,
    output logic [1:0]  o_flips
);

    localparam int IW = $clog2(MAX_BITS);
    localparam int CW = $clog2(MAX_BITS + 1);
    localparam int EW = CW + 2;
    localparam logic [MAX_BITS-1:0] ONE = MAX_BITS'(1);

    // Configuration and effective word length.
    logic [5:0]          r_word_length;
    logic [6:0]          len_full;
    logic [CW-1:0]       eff_len;
    logic [MAX_BITS-1:0] mask;
    logic [EW-1:0]       len_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_length <= WORD_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_word_length <= i_cfg_data;
        end
    end

    assign len_full = ({1'b0, r_word_length} > 7'(MAX_BITS)) ? 7'(MAX_BITS)
                                                               : {1'b0, r_word_length};
    assign eff_len  = len_full[CW-1:0];
    assign len_e    = EW'(eff_len);

    always_comb begin
        for (int k = 0; k < MAX_BITS; k++) begin
            mask[k] = (k < int'(eff_len));
        end
    end

    // Basis unit: holds the echelon rows and reduces one word at a time.
    t_red_req            red_req;
    t_red_rsp            red_rsp;
    logic [MAX_BITS-1:0] red_word;
    logic [MAX_BITS-1:0] red_rem;

    lcbd_basis #(
        .MAX_BITS (MAX_BITS)
    ) u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (red_req),
        .i_word  (red_word),
        .i_len   (eff_len),
        .i_mask  (mask),
        .o_rsp   (red_rsp),
        .o_rem   (red_rem)
    );

    // Syndrome table: entry a holds the reduction of the single bit a.
    // Reduction is linear, so a flip pattern is a codeword neighbor exactly
    // when the table entries of its bits XOR to the syndrome of the word.
    logic [MAX_BITS-1:0] tab_mem [MAX_BITS];
    logic [MAX_BITS-1:0] r_tdata;
    logic [IW-1:0]       t_rd;
    logic                t_we;

    t_state              r_state, n_state;
    t_job                r_job, n_job;
    logic [MAX_BITS-1:0] r_x, n_x;
    logic [MAX_BITS-1:0] r_s, n_s;
    logic [MAX_BITS-1:0] r_pp, n_pp;
    logic [MAX_BITS-1:0] r_best, n_best;
    logic [CW-1:0]       r_a, n_a;
    logic [CW-1:0]       r_b, n_b;
    logic [CW-1:0]       r_c, n_c;
    logic [CW-1:0]       r_cd, n_cd;
    logic [1:0]          r_lvl, n_lvl;
    logic                r_hit, n_hit;
    logic                r_dv, n_dv;
    logic                r_ov, n_ov;
    logic                r_of, n_of;
    logic [31:0]         r_ocw, n_ocw;
    logic [1:0]          r_ofl, n_ofl;

    logic                accept;
    logic [MAX_BITS-1:0] xw;
    logic [MAX_BITS-1:0] emask;
    logic [MAX_BITS-1:0] cand;
    logic                hit_now;
    logic [EW-1:0]       a_e, b_e, c_e;

    assign o_stall    = (r_state != S_IDLE);
    assign accept     = i_valid && !o_stall;
    assign xw         = MAX_BITS'(i_data_word) & mask;
    assign o_valid    = r_ov;
    assign o_found    = r_of;
    assign o_codeword = r_ocw;
    assign o_flips    = r_ofl;

    assign a_e = EW'(r_a);
    assign b_e = EW'(r_b);
    assign c_e = EW'(r_c);

    // A candidate is the received word with the prefix bits and the streamed
    // bit flipped; it is a codeword when its syndrome comes out zero.
    always_comb begin
        emask = ONE << r_cd[IW-1:0];
        if (r_lvl >= 2'd2) begin
            emask = emask | (ONE << r_a[IW-1:0]);
        end
        if (r_lvl == 2'd3) begin
            emask = emask | (ONE << r_b[IW-1:0]);
        end
    end
    assign cand    = r_x ^ emask;
    assign hit_now = r_dv && ((r_pp ^ r_tdata) == '0)
                     && ((r_state == S_STR) || (r_state == S_DRN));

    always_ff @(posedge i_clk) begin
        r_tdata <= tab_mem[t_rd];
        if (t_we) begin
            tab_mem[r_a[IW-1:0]] <= red_rem;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_x      = r_x;
        n_s      = r_s;
        n_pp     = r_pp;
        n_best   = r_best;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_cd     = r_cd;
        n_lvl    = r_lvl;
        n_hit    = r_hit;
        n_dv     = r_dv;
        n_ov     = r_ov && i_stall;
        n_of     = r_of;
        n_ocw    = r_ocw;
        n_ofl    = r_ofl;
        red_req  = '0;
        red_word = xw;
        t_rd     = r_c[IW-1:0];
        t_we     = 1'b0;

        if (hit_now) begin
            if (!r_hit || (cand < r_best)) begin
                n_best = cand;
            end
            n_hit = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_command))
                        CMD_CLEAR: begin
                            red_req.clear = 1'b1;
                        end
                        CMD_INSERT: begin
                            red_req.start  = 1'b1;
                            red_req.insert = 1'b1;
                            n_job          = JOB_INSERT;
                            n_state        = S_RED;
                        end
                        CMD_DECODE: begin
                            red_req.start = 1'b1;
                            n_job         = JOB_SYND;
                            n_x           = xw;
                            n_hit         = 1'b0;
                            n_state       = S_RED;
                        end
                        CMD_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RED: begin
                red_word = (ONE << r_a[IW-1:0]) & mask;
                if (red_rsp.done) begin
                    unique case (r_job)
                        JOB_INSERT: begin
                            n_state = S_IDLE;
                        end
                        JOB_SYND: begin
                            n_s = red_rem;
                            if (red_rem == '0) begin
                                // The received word is itself a codeword.
                                n_hit   = 1'b1;
                                n_best  = r_x;
                                n_lvl   = 2'd0;
                                n_state = S_FIN;
                            end else begin
                                n_job         = JOB_TABLE;
                                n_a           = '0;
                                red_word      = ONE & mask;
                                red_req.start = 1'b1;
                            end
                        end
                        JOB_TABLE: begin
                            t_we = 1'b1;
                            if (a_e + EW'(1) < len_e) begin
                                n_a           = r_a + CW'(1);
                                red_word      = (ONE << n_a[IW-1:0]) & mask;
                                red_req.start = 1'b1;
                            end else begin
                                n_lvl   = 2'd1;
                                n_pp    = r_s;
                                n_c     = '0;
                                n_dv    = 1'b0;
                                n_state = S_STR;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PA: begin
                t_rd    = r_a[IW-1:0];
                n_state = S_PB;
            end
            S_PB: begin
                t_rd = r_b[IW-1:0];
                n_pp = r_s ^ r_tdata;
                if (r_lvl == 2'd3) begin
                    n_state = S_PC;
                end else begin
                    n_c     = r_a + CW'(1);
                    n_state = S_STR;
                end
            end
            S_PC: begin
                n_pp    = r_pp ^ r_tdata;
                n_c     = r_b + CW'(1);
                n_state = S_STR;
            end
            S_STR: begin
                t_rd = r_c[IW-1:0];
                n_cd = r_c;
                n_dv = 1'b1;
                if (c_e + EW'(1) >= len_e) begin
                    n_state = S_DRN;
                end else begin
                    n_c = r_c + CW'(1);
                end
            end
            S_DRN: begin
                n_dv = 1'b0;
                // Advance the prefix; at the end of a weight stop on a hit, move on to
                // the next weight, or stop when no further weight fits the length.
                if ((r_lvl == 2'd2) && (a_e + EW'(3) <= len_e)) begin
                    n_a     = r_a + CW'(1);
                    n_state = S_PA;
                end else if ((r_lvl == 2'd3) && (b_e + EW'(3) <= len_e)) begin
                    n_b     = r_b + CW'(1);
                    n_state = S_PA;
                end else if ((r_lvl == 2'd3) && (a_e + EW'(4) <= len_e)) begin
                    n_a     = r_a + CW'(1);
                    n_b     = r_a + CW'(2);
                    n_state = S_PA;
                end else if (n_hit) begin
                    n_state = S_FIN;
                end else if ((r_lvl == 2'd1) && (len_e >= EW'(2))) begin
                    n_lvl   = 2'd2;
                    n_a     = '0;
                    n_state = S_PA;
                end else if ((r_lvl == 2'd2) && (len_e >= EW'(3))) begin
                    n_lvl   = 2'd3;
                    n_a     = '0;
                    n_b     = CW'(1);
                    n_state = S_PA;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Wait here only while the previous result is still held.
                if (!r_ov || !i_stall) begin
                    n_ov    = 1'b1;
                    n_of    = r_hit;
                    n_ocw   = r_hit ? 32'(r_best) : 32'd0;
                    n_ofl   = r_hit ? r_lvl : 2'd0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_hit   <= 1'b0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_hit   <= n_hit;
            r_dv    <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_x    <= n_x;
        r_s    <= n_s;
        r_pp   <= n_pp;
        r_best <= n_best;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_cd   <= n_cd;
        r_lvl  <= n_lvl;
        r_of   <= n_of;
        r_ocw  <= n_ocw;
        r_ofl  <= n_ofl;
    end

endmodule
`default_nettype wire

// ===== dv/tb_linear_code_bounded_distance_decoder.sv =====
module tb_linear_code_bounded_distance_decoder;
    import lcbd_pkg::*;

    // The clock period is 4 time units. Decode runs are bounded by the syndrome search,
    // so the watchdog is loose.
    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int QUIET_CYCLES  = 80;
    localparam int TAIL_ITEMS    = 15;
    localparam int TIMEOUT_TIME  = 4 * 3000000;

    // One entry of the stimulus plan: either a register write or a command transfer.
    typedef struct {
        bit          is_cfg;
        logic [5:0]  cfg_value;
        t_cmd        cmd;
        logic [31:0] data;
    } t_plan;

    typedef struct {
        logic        found;
        logic [31:0] codeword;
        logic [1:0]  flips;
    } t_decode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [5:0]  i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_command;
    logic [31:0] i_data_word;
    logic        o_valid;
    logic        i_stall;
    logic        o_found;
    logic [31:0] o_codeword;
    logic [1:0]  o_flips;

    linear_code_bounded_distance_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_data_word (i_data_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_found     (o_found),
        .o_codeword  (o_codeword),
        .o_flips     (o_flips)
    );

    t_plan   plan_q[$];
    t_decode pending_decodes[$];
    int      error_count;
    int      decodes_seen;
    bit      plan_ready;

    // The testbench keeps its own copy of the basis, the pivot flags and the length.
    logic [31:0] basis_copy[32];
    logic [31:0] pivots_copy;
    logic [5:0]  length_copy;

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch on %s: got 0x%08h, expected 0x%08h", what, got, want);
        error_count++;
    endtask

    // Effective length: anything above the 32 bits of the datapath acts as 32.
    function automatic int eff_length();
        return (length_copy > 6'd32) ? 32 : int'(length_copy);
    endfunction

    function automatic logic [31:0] length_mask(input int len);
        logic [32:0] full;
        full = (33'd1 << len) - 33'd1;
        return full[31:0];
    endfunction

    // Reduce a word by the stored pivots from bit zero upward.
    function automatic logic [31:0] reduce_word(input logic [31:0] w, input int len,
                                                input logic [31:0] m);
        logic [31:0] r;
        r = w & m;
        for (int i = 0; i < len; i++) begin
            if (r[i] && pivots_copy[i]) begin
                r = r ^ (basis_copy[i] & m);
            end
        end
        return r;
    endfunction

    function automatic t_decode decode_word(input logic [31:0] x, input int len,
                                            input logic [31:0] m);
        t_decode     res;
        logic [31:0] cand;
        res = '{found: 1'b0, codeword: 32'd0, flips: 2'd0};
        // Weight zero first, then each heavier weight only if nothing lighter hit.
        for (int wt = 0; wt <= 3 && !res.found; wt++) begin
            for (int a = 0; a < ((wt >= 1) ? len : 1); a++) begin
                for (int b = a + 1; b < ((wt >= 2) ? len : a + 2); b++) begin
                    for (int c = b + 1; c < ((wt >= 3) ? len : b + 2); c++) begin
                        cand = x;
                        if (wt >= 1) cand[a] = ~cand[a];
                        if (wt >= 2) cand[b] = ~cand[b];
                        if (wt >= 3) cand[c] = ~cand[c];
                        if (reduce_word(cand, len, m) == 32'd0) begin
                            if (!res.found || cand < res.codeword) res.codeword = cand;
                            res.found = 1'b1;
                            res.flips = wt[1:0];
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    // Apply one accepted command transfer to the predicted state.
    task automatic predict_command(input t_cmd cmd, input logic [31:0] data);
        int          len;
        logic [31:0] m;
        logic [31:0] rem;
        t_decode     res;
        len = eff_length();
        m   = length_mask(len);
        case (cmd)
            CMD_CLEAR: begin
                pivots_copy = 32'd0;
            end
            CMD_INSERT: begin
                rem = reduce_word(data, len, m);
                for (int i = 0; i < len; i++) begin
                    if (rem[i]) begin
                        basis_copy[i]  = rem;
                        pivots_copy[i] = 1'b1;
                        break;
                    end
                end
            end
            CMD_DECODE: begin
                res = decode_word(data & m, len, m);
                pending_decodes.insert(pending_decodes.size(), res);
            end
            default: begin
            end
        endcase
    endtask

    task automatic add_cfg(input int len);
        t_plan item;
        item = '{is_cfg: 1'b1, cfg_value: len[5:0], cmd: CMD_NOP, data: 32'd0};
        plan_q.insert(plan_q.size(), item);
    endtask

    task automatic add_cmd(input t_cmd cmd, input logic [31:0] data);
        t_plan item;
        item = '{is_cfg: 1'b0, cfg_value: 6'd0, cmd: cmd, data: data};
        plan_q.insert(plan_q.size(), item);
    endtask

    // A random phase: mostly a fresh set of generators followed by decodes of
    // codewords with up to three flipped bits, mixed with noise words.
    task automatic random_phase(input int len, input int n);
        logic [31:0] gens[$];
        logic [31:0] word;
        int          k;
        if ($urandom_range(0, 3) != 0) add_cmd(CMD_CLEAR, $urandom());
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) begin
            word = $urandom();
            gens.insert(gens.size(), word);
            add_cmd(CMD_INSERT, word);
        end
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: add_cmd(CMD_NOP, $urandom());
                1: add_cmd(CMD_INSERT, $urandom());
                2, 3: add_cmd(CMD_DECODE, $urandom());
                default: begin
                    // Random combination of generators, bits above the length left random.
                    word = $urandom() & ~length_mask((len > 32) ? 32 : len);
                    foreach (gens[g]) if ($urandom_range(0, 1)) word ^= gens[g];
                    for (int f = $urandom_range(0, 3); f > 0; f--) begin
                        if (len > 0) word[$urandom_range(0, ((len > 32) ? 32 : len) - 1)] ^= 1'b1;
                    end
                    add_cmd(CMD_DECODE, word);
                end
            endcase
        end
    endtask

    initial begin
        int lens[8] = '{5, 3, 16, 10, 7, 12, 6, 9};
        // Directed part at the reset length of 32.
        add_cmd(CMD_CLEAR, 32'hFFFF_FFFF);
        add_cmd(CMD_DECODE, 32'h0000_0000);
        add_cmd(CMD_INSERT, 32'h0000_0001);
        add_cmd(CMD_INSERT, 32'h8000_0000);
        add_cmd(CMD_INSERT, 32'hFFFF_FFFF);
        add_cmd(CMD_INSERT, 32'h0000_0000);
        add_cmd(CMD_INSERT, 32'h8000_0001);
        add_cmd(CMD_DECODE, 32'h7FFF_FFFF);
        add_cmd(CMD_DECODE, 32'h0F0F_0F0F);
        add_cmd(CMD_NOP, 32'h1234_5678);
        // Zero length: everything masks away and codeword zero is always found.
        add_cfg(0);
        add_cmd(CMD_INSERT, 32'hDEAD_BEEF);
        add_cmd(CMD_DECODE, 32'hFFFF_FFFF);
        // Oversized length, with the rows stored at full length still in place.
        add_cfg(63);
        add_cmd(CMD_DECODE, 32'h8000_0003);
        // Length of one; the stored rows are used masked to the new length.
        add_cfg(1);
        add_cmd(CMD_DECODE, 32'h0000_0001);
        add_cmd(CMD_CLEAR, 32'd0);
        add_cmd(CMD_DECODE, 32'hFFFF_FFFE);
        add_cmd(CMD_INSERT, 32'h0000_0001);
        add_cmd(CMD_DECODE, 32'h0000_0001);
        // A basis that leaves some words more than three flips away.
        add_cfg(8);
        add_cmd(CMD_CLEAR, 32'd0);
        add_cmd(CMD_INSERT, 32'h0000_00FF);
        add_cmd(CMD_DECODE, 32'h0000_000F);
        add_cmd(CMD_DECODE, 32'h0000_0007);
        foreach (lens[i]) begin
            add_cfg(lens[i]);
            random_phase(lens[i], $urandom_range(5, 8));
        end
        add_cfg(32);
        random_phase(32, 2);
        plan_ready = 1'b1;
    end

    // Driver: feeds the command port from the plan and issues register writes
    // only once the block has gone quiet.
    int          gap_count;
    int          quiet_count;
    t_plan       head;
    bit          drive_valid;
    bit          cfg_we_next;
    int          gap_next;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_cfg_we    <= 1'b0;
            gap_count   <= 0;
            quiet_count <= 0;
        end else begin
            drive_valid = i_valid;
            cfg_we_next = 1'b0;
            gap_next    = gap_count;
            if (i_valid && !o_stall) begin
                // Transfer accepted at this edge.
                predict_command(t_cmd'(i_command), i_data_word);
                drive_valid = 1'b0;
                quiet_count <= 0;
                if (plan_q.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
                    gap_next = $urandom_range(1, 18);
                end
            end else begin
                quiet_count <= quiet_count + 1;
            end
            if (!drive_valid && plan_ready && plan_q.size() > 0) begin
                head = plan_q[0];
                if (gap_next > 0) begin
                    gap_next = gap_next - 1;
                end else if (head.is_cfg) begin
                    if (pending_decodes.size() == 0 && quiet_count >= QUIET_CYCLES) begin
                        cfg_we_next = 1'b1;
                        i_cfg_data  <= head.cfg_value;
                        length_copy = head.cfg_value;
                        void'(plan_q.pop_front());
                    end
                end else begin
                    drive_valid = 1'b1;
                    i_command   <= head.cmd;
                    i_data_word <= head.data;
                    void'(plan_q.pop_front());
                end
            end
            i_valid   <= drive_valid;
            i_cfg_we  <= cfg_we_next;
            gap_count <= gap_next;
        end
    end

    // Receiver stall: random bursts, one long hold-off while the sender keeps
    // offering so that the block backs up, and no stalls near the end.
    int  stall_burst;
    int  hold_count;
    bit  hold_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            stall_burst <= 0;
            hold_count  <= 0;
            hold_done   <= 1'b0;
        end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            i_stall    <= 1'b1;
        end else if (!hold_done && decodes_seen >= 12) begin
            hold_done  <= 1'b1;
            hold_count <= 400;
            i_stall    <= 1'b1;
        end else if (stall_burst > 0) begin
            stall_burst <= stall_burst - 1;
            i_stall     <= 1'b1;
        end else if (plan_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
            stall_burst <= $urandom_range(0, 17);
            i_stall     <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: each result transfer is checked against the oldest prediction.
    t_decode want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            decodes_seen <= decodes_seen + 1;
            if (pending_decodes.size() == 0) begin
                $display("result transfer with no decode outstanding");
                error_count++;
            end else begin
                want = pending_decodes.pop_front();
                if (o_found !== want.found) report("found", 32'(o_found), 32'(want.found));
                if (o_codeword !== want.codeword) report("codeword", o_codeword, want.codeword);
                if (o_flips !== want.flips) report("flips", 32'(o_flips), 32'(want.flips));
            end
        end
    end

    initial begin
        error_count  = 0;
        decodes_seen = 0;
        pivots_copy  = 32'd0;
        length_copy  = WORD_LENGTH_RESET;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = 6'd0;
        i_valid      = 1'b0;
        i_command    = CMD_NOP;
        i_data_word  = 32'd0;
        i_stall      = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Wait for the plan to drain and every predicted decode to come back.
        @(posedge i_clk);
        while (!plan_ready || plan_q.size() > 0 || i_valid || pending_decodes.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && pending_decodes.size() == 0) begin
            $display("tb_linear_code_bounded_distance_decoder: done, clean");
        end else begin
            $display("tb_linear_code_bounded_distance_decoder: done, errors");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_TIME;
        $display("tb_linear_code_bounded_distance_decoder: done, errors");
        $finish;
    end

endmodule
